// ===== hw/rtl/ptw_pkg.sv =====
// Package with the types, codes and helper functions of the page table walker.
package ptw_pkg;

   // Physical address width that bounds the frame taken from an entry.
   localparam int PHYS_ADDR_BITS = 48;
   localparam int ADDR_W         = 48;
   localparam int DATA_W         = 64;
   localparam int MASK_BITS      = (PHYS_ADDR_BITS < ADDR_W) ? PHYS_ADDR_BITS : ADDR_W;

   // Frame bits of an entry or root, cut to the width of the address fields.
   localparam logic [ADDR_W-1:0] ADDR_ONE   = ADDR_W'(1);
   localparam logic [ADDR_W-1:0] FRAME_MASK =
      ((ADDR_ONE << MASK_BITS) - ADDR_ONE) & ~ADDR_W'(12'hFFF);

   // Present and page-size bits of a table entry.
   localparam int PRESENT_BIT = 0;
   localparam int PAGE_SIZE_BIT = 7;

   // Function codes of an input beat.
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_DATA  = 1'b1;

   // Table levels.
   localparam logic [1:0] LEVEL_PML4 = 2'd0;
   localparam logic [1:0] LEVEL_PDPT = 2'd1;
   localparam logic [1:0] LEVEL_PD   = 2'd2;
   localparam logic [1:0] LEVEL_PT   = 2'd3;

   // Kinds of result beat.
   typedef enum logic [1:0] {
      KIND_READ    = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_IGNORED = 2'd2
   } kind_type;

   typedef struct packed {
      logic              func;
      logic [ADDR_W-1:0] vaddr;
      logic [ADDR_W-1:0] table_base;
      logic [DATA_W-1:0] read_data;
   } req_type;

   typedef struct packed {
      kind_type          kind;
      logic [ADDR_W-1:0] next_address;
      logic [1:0]        level;
      logic [DATA_W-1:0] entry_value;
      logic [ADDR_W-1:0] entry_address;
      logic              entry_valid;
   } rsp_type;

   // Nine-bit table index of a virtual address for one level.
   function automatic logic [8:0] table_index(input logic [ADDR_W-1:0] va,
                                              input logic [1:0] lvl);
      logic [8:0] idx;
      case (lvl)
         LEVEL_PML4: idx = va[47:39];
         LEVEL_PDPT: idx = va[38:30];
         LEVEL_PD:   idx = va[29:21];
         LEVEL_PT:   idx = va[20:12];
         default:    idx = va[47:39];
      endcase
      return idx;
   endfunction

   // Entry address: frame base plus index times eight. The frame has its low
   // twelve bits clear, so the index simply fills bits 11..3.
   function automatic logic [ADDR_W-1:0] entry_addr(input logic [ADDR_W-1:0] base,
                                                    input logic [ADDR_W-1:0] va,
                                                    input logic [1:0] lvl);
      logic [ADDR_W-1:0] frame;
      frame = base & FRAME_MASK;
      return {frame[ADDR_W-1:12], table_index(va, lvl), 3'b000};
   endfunction

endpackage

// ===== hw/rtl/page_table_walker.sv =====
// Top level: four-level page table walker with registered input and result stages.
// A beat is held in the input register and moves into the result register once that is free.
// Throughput: one beat per cycle while the receiver does not stall; the input
// register takes a new beat while a finished result waits to be taken only if
// it is empty, and a beat leaves it whenever the result register is free or being emptied.
// Reset (synchronous, active high) empties both stages and ends any walk.
module page_table_walker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ptw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ptw_pkg::rsp_type rsp_data
);

   logic                       req_valid_ff, req_valid_in;
   ptw_pkg::req_type           req_data_ff, req_data_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   ptw_pkg::rsp_type           rsp_data_ff, rsp_data_in;
   logic                       busy_ff, busy_in;
   logic [1:0]                 level_ff, level_in;
   logic [ptw_pkg::ADDR_W-1:0] vaddr_ff, vaddr_in;
   logic [ptw_pkg::ADDR_W-1:0] pending_ff, pending_in;

   logic rsp_free, advance, req_take;
   logic present, big_page, done;
   logic [1:0] next_level;

   // Handshake between the two stages.
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && rsp_free;
   assign req_stall = req_valid_ff && !rsp_free;
   assign req_take  = req_valid && !req_stall;

   // Input register control.
   always_comb begin
      req_valid_in = req_valid_ff;
      req_data_in  = req_data_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
         req_data_in  = req_data;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
   end

   // Entry checks for a returned read.
   assign present    = req_data_ff.read_data[ptw_pkg::PRESENT_BIT];
   assign big_page   = ((level_ff == ptw_pkg::LEVEL_PDPT) || (level_ff == ptw_pkg::LEVEL_PD))
                       && req_data_ff.read_data[ptw_pkg::PAGE_SIZE_BIT];
   assign done       = !present || big_page || (level_ff == ptw_pkg::LEVEL_PT);
   assign next_level = level_ff + 2'd1;

   // Walk step for the beat in the input register.
   always_comb begin
      busy_in    = busy_ff;
      level_in   = level_ff;
      vaddr_in   = vaddr_ff;
      pending_in = pending_ff;
      rsp_data_in               = '0;
      rsp_data_in.kind          = ptw_pkg::KIND_IGNORED;
      if (req_data_ff.func == ptw_pkg::FUNC_START) begin
         if (!busy_ff) begin
            busy_in    = 1'b1;
            level_in   = ptw_pkg::LEVEL_PML4;
            vaddr_in   = req_data_ff.vaddr;
            pending_in = ptw_pkg::entry_addr(req_data_ff.table_base,
                                             req_data_ff.vaddr,
                                             ptw_pkg::LEVEL_PML4);
            rsp_data_in.kind         = ptw_pkg::KIND_READ;
            rsp_data_in.next_address = pending_in;
         end
      end else if (busy_ff) begin
         rsp_data_in.level         = level_ff;
         rsp_data_in.entry_value   = req_data_ff.read_data;
         rsp_data_in.entry_address = pending_ff;
         rsp_data_in.entry_valid   = 1'b1;
         if (done) begin
            busy_in          = 1'b0;
            level_in         = ptw_pkg::LEVEL_PML4;
            rsp_data_in.kind = ptw_pkg::KIND_DONE;
         end else begin
            level_in   = next_level;
            pending_in = ptw_pkg::entry_addr(req_data_ff.read_data[ptw_pkg::ADDR_W-1:0],
                                             vaddr_ff, next_level);
            rsp_data_in.kind         = ptw_pkg::KIND_READ;
            rsp_data_in.next_address = pending_in;
         end
      end
   end

   // Result valid: set by an advancing beat, cleared once taken.
   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
         level_ff     <= ptw_pkg::LEVEL_PML4;
         vaddr_ff     <= '0;
         pending_ff   <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            busy_ff    <= busy_in;
            level_ff   <= level_in;
            vaddr_ff   <= vaddr_in;
            pending_ff <= pending_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/ptw_checker.sv =====
// Port-level checker for the page table walker and its bind statement.
module ptw_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ptw_pkg::rsp_type rsp_data
);

   // A stalled result beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // An ignored beat carries nothing but its kind.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == ptw_pkg::KIND_IGNORED) |->
      (rsp_data.next_address == '0) && (rsp_data.level == 2'd0) &&
      (rsp_data.entry_value == '0) && (rsp_data.entry_address == '0) &&
      !rsp_data.entry_valid)
      else $error("ignored beat with nonzero fields");

   // A finished walk always reports the entry that ended it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == ptw_pkg::KIND_DONE) |-> rsp_data.entry_valid)
      else $error("walk done without an entry");

   // The PT entry always ends the walk, so no read follows it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == ptw_pkg::KIND_READ) && rsp_data.entry_valid |->
      (rsp_data.level != ptw_pkg::LEVEL_PT))
      else $error("read requested past the PT level");

   // The answer to a start asks for the PML4 entry.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == ptw_pkg::KIND_READ) && !rsp_data.entry_valid |->
      (rsp_data.level == ptw_pkg::LEVEL_PML4) && (rsp_data.next_address[2:0] == 3'b000))
      else $error("bad start answer");

endmodule

bind page_table_walker ptw_checker u_ptw_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the four-level page table walker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Frame bits of an entry or root: bits PHYS_ADDR_BITS-1..12, cut to 48 bits.
   localparam int          FRAME_TOP    =
      (ptw_pkg::PHYS_ADDR_BITS < 48) ? ptw_pkg::PHYS_ADDR_BITS : 48;
   localparam logic [63:0] FRAME_WIDE   = ((64'd1 << FRAME_TOP) - 64'd1) & ~64'hFFF;
   localparam logic [47:0] FRAME_BITS   = FRAME_WIDE[47:0];
   localparam int          WALK_BEATS   = 1700;
   localparam int          QUIET_LIMIT  = 4000;
   localparam int          SETTLE_TICKS = 8;

   // One row of the directed table; the answer is typed in only where marked.
   typedef struct {
      ptw_pkg::req_type beat;
      bit               typed;
      ptw_pkg::rsp_type answer;
   } vec_row_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   ptw_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   ptw_pkg::rsp_type rsp_data;

   // Shadow copy of the walker's state.
   logic        pt_busy       = 1'b0;
   logic [1:0]  pt_level      = ptw_pkg::LEVEL_PML4;
   logic [47:0] pt_vaddr      = '0;
   logic [47:0] pt_entry_addr = '0;

   vec_row_type      directed_rows[$];
   vec_row_type      typed_answers[$];
   ptw_pkg::rsp_type answers_due[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatches     = 0;
   int quiet_cycles   = 0;
   int answers_seen   = 0;
   int walks_ended    = 0;
   int beats_ignored  = 0;
   int walks_started  = 0;
   int walk_beats     = 0;
   int stray_beats    = 0;

   page_table_walker uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 100 MHz clock.
   always begin
      #5ns clock = 1'b1;
      #5ns clock = 1'b0;
   end

   function automatic logic [47:0] rand48();
      return 48'({$urandom, $urandom});
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic ptw_pkg::req_type start_beat(input logic [47:0] va,
                                                   input logic [47:0] root);
      ptw_pkg::req_type b;
      b = '0;
      b.func = ptw_pkg::FUNC_START;
      b.vaddr = va;
      b.table_base = root;
      return b;
   endfunction

   function automatic ptw_pkg::req_type data_beat(input logic [63:0] entry);
      ptw_pkg::req_type b;
      b = '0;
      b.func = ptw_pkg::FUNC_DATA;
      b.read_data = entry;
      return b;
   endfunction

   function automatic ptw_pkg::rsp_type answer_of(input ptw_pkg::kind_type k,
                                                  input logic [47:0] next,
                                                  input logic [1:0] lvl,
                                                  input logic [63:0] value,
                                                  input logic [47:0] addr,
                                                  input logic valid);
      ptw_pkg::rsp_type a;
      a.kind = k;
      a.next_address = next;
      a.level = lvl;
      a.entry_value = value;
      a.entry_address = addr;
      a.entry_valid = valid;
      return a;
   endfunction

   // Address of the entry for one level: frame base plus nine-bit index times eight.
   function automatic logic [47:0] entry_location(input logic [47:0] base,
                                                  input logic [47:0] va,
                                                  input logic [1:0] lvl);
      logic [5:0] shift;
      logic [8:0] idx;
      shift = 6'd39 - 6'd9 * {4'd0, lvl};
      idx = 9'(va >> shift);
      return (base & FRAME_BITS) + {36'd0, idx, 3'b000};
   endfunction

   // Works out the answer to one accepted beat and advances the shadow walk.
   function automatic ptw_pkg::rsp_type walk_step_answer(input ptw_pkg::req_type b);
      ptw_pkg::rsp_type a;
      logic             big_page;
      a = '0;
      a.kind = ptw_pkg::KIND_IGNORED;
      if (b.func == ptw_pkg::FUNC_START) begin
         if (!pt_busy) begin
            pt_busy = 1'b1;
            pt_level = ptw_pkg::LEVEL_PML4;
            pt_vaddr = b.vaddr;
            pt_entry_addr = entry_location(b.table_base, b.vaddr, ptw_pkg::LEVEL_PML4);
            a.kind = ptw_pkg::KIND_READ;
            a.next_address = pt_entry_addr;
         end
      end else if (pt_busy) begin
         big_page = (pt_level == ptw_pkg::LEVEL_PDPT || pt_level == ptw_pkg::LEVEL_PD) &&
                    b.read_data[ptw_pkg::PAGE_SIZE_BIT];
         a.level = pt_level;
         a.entry_value = b.read_data;
         a.entry_address = pt_entry_addr;
         a.entry_valid = 1'b1;
         if (!b.read_data[ptw_pkg::PRESENT_BIT] || big_page ||
             pt_level == ptw_pkg::LEVEL_PT) begin
            pt_busy = 1'b0;
            pt_level = ptw_pkg::LEVEL_PML4;
            a.kind = ptw_pkg::KIND_DONE;
         end else begin
            pt_level = pt_level + 2'd1;
            pt_entry_addr = entry_location(b.read_data[47:0], pt_vaddr, pt_level);
            a.kind = ptw_pkg::KIND_READ;
            a.next_address = pt_entry_addr;
         end
      end
      return a;
   endfunction

   task automatic flag_error(input string what, input logic [63:0] want,
                             input logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: mismatch in %s: expected %h, got %h", $realtime, what, want, got);
   endtask

   task automatic compare_answer(input ptw_pkg::rsp_type want, input ptw_pkg::rsp_type got);
      if (got.kind !== want.kind)
         flag_error("kind", 64'(want.kind), 64'(got.kind));
      if (got.next_address !== want.next_address)
         flag_error("next_address", 64'(want.next_address), 64'(got.next_address));
      if (got.level !== want.level)
         flag_error("level", 64'(want.level), 64'(got.level));
      if (got.entry_value !== want.entry_value)
         flag_error("entry_value", want.entry_value, got.entry_value);
      if (got.entry_address !== want.entry_address)
         flag_error("entry_address", 64'(want.entry_address), 64'(got.entry_address));
      if (got.entry_valid !== want.entry_valid)
         flag_error("entry_valid", 64'(want.entry_valid), 64'(got.entry_valid));
   endtask

   // Receiver side: random stall at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Monitor: predicts on every accepted input beat and checks every accepted result.
   always @(posedge clock) begin : monitor
      ptw_pkg::rsp_type want;
      vec_row_type      row;
      logic             moved;
      if (!reset) begin
         moved = (req_valid && !req_stall) || (rsp_valid && !rsp_stall);
         if (moved)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (req_valid && !req_stall) begin
            want = walk_step_answer(req_data);
            row = typed_answers.pop_front();
            if (row.typed)
               want = row.answer;
            answers_due.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            answers_seen++;
            if (rsp_data.kind == ptw_pkg::KIND_DONE)
               walks_ended++;
            if (rsp_data.kind == ptw_pkg::KIND_IGNORED)
               beats_ignored++;
            if (answers_due.size() == 0)
               flag_error("result beat with nothing expected, kind", '0, 64'(rsp_data.kind));
            else
               compare_answer(answers_due.pop_front(), rsp_data);
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $realtime, QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Presents one beat after a random gap and holds it until it is taken.
   task automatic send_beat(input ptw_pkg::req_type b, input bit typed,
                            input ptw_pkg::rsp_type answer);
      vec_row_type row;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      row.beat = b;
      row.typed = typed;
      row.answer = answer;
      typed_answers.push_back(row);
      req_valid <= 1'b1;
      req_data <= b;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic add_row(input ptw_pkg::req_type b, input bit typed,
                          input ptw_pkg::rsp_type answer);
      vec_row_type row;
      row.beat = b;
      row.typed = typed;
      row.answer = answer;
      directed_rows.push_back(row);
   endtask

   // Now and then a beat with every field random: a stray start or stray data.
   task automatic maybe_stray();
      ptw_pkg::req_type b;
      if ($urandom_range(0, 99) < 6) begin
         b.func = 1'($urandom);
         b.vaddr = rand48();
         b.table_base = rand48();
         b.read_data = rand64();
         send_beat(b, 1'b0, '0);
         stray_beats++;
      end
   endtask

   // One well-formed walk with random content; the walk stops where the entry says.
   task automatic run_walk();
      logic [63:0] entry;
      int          lvl;
      bit          stop;
      maybe_stray();
      send_beat(start_beat(rand48(), rand48()), 1'b0, '0);
      walks_started++;
      walk_beats++;
      stop = 1'b0;
      for (lvl = 0; lvl < 4 && !stop; lvl++) begin
         entry = rand64();
         entry[ptw_pkg::PRESENT_BIT] = ($urandom_range(0, 99) < 88);
         if (lvl == 1 || lvl == 2)
            entry[ptw_pkg::PAGE_SIZE_BIT] = ($urandom_range(0, 99) < 25);
         maybe_stray();
         send_beat(data_beat(entry), 1'b0, '0);
         walk_beats++;
         stop = !entry[ptw_pkg::PRESENT_BIT] || lvl == 3 ||
                ((lvl == 1 || lvl == 2) && entry[ptw_pkg::PAGE_SIZE_BIT]);
      end
   endtask

   // Stimulus: reset, directed table, then random walks in three idling phases.
   initial begin : stimulus
      ptw_pkg::req_type b;
      int               i;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Data right after reset, with every field at its maximum, is ignored.
      b = data_beat('1);
      b.vaddr = '1;
      b.table_base = '1;
      add_row(b, 1'b1, answer_of(ptw_pkg::KIND_IGNORED, '0, ptw_pkg::LEVEL_PML4,
                                 '0, '0, 1'b0));
      // Start with root and address all ones.
      add_row(start_beat('1, '1), 1'b1,
              answer_of(ptw_pkg::KIND_READ, 48'hFFFF_FFFF_FFF8, ptw_pkg::LEVEL_PML4,
                        '0, '0, 1'b0));
      // A start while a walk runs is ignored.
      add_row(start_beat('0, '0), 1'b1,
              answer_of(ptw_pkg::KIND_IGNORED, '0, ptw_pkg::LEVEL_PML4, '0, '0, 1'b0));
      // All-ones entries: PML4 goes on, the PDPT one is a 1G page.
      add_row(data_beat('1), 1'b1,
              answer_of(ptw_pkg::KIND_READ, 48'hFFFF_FFFF_FFF8, ptw_pkg::LEVEL_PML4, '1,
                        48'hFFFF_FFFF_FFF8, 1'b1));
      add_row(data_beat('1), 1'b1,
              answer_of(ptw_pkg::KIND_DONE, '0, ptw_pkg::LEVEL_PDPT, '1,
                        48'hFFFF_FFFF_FFF8, 1'b1));
      // Data while idle after a finished walk.
      add_row(data_beat('0), 1'b1,
              answer_of(ptw_pkg::KIND_IGNORED, '0, ptw_pkg::LEVEL_PML4, '0, '0, 1'b0));
      // Low twelve bits of the root are dropped; a zero PML4 entry ends the walk.
      add_row(start_beat('0, 48'hFFF), 1'b1,
              answer_of(ptw_pkg::KIND_READ, '0, ptw_pkg::LEVEL_PML4, '0, '0, 1'b0));
      add_row(data_beat('0), 1'b1,
              answer_of(ptw_pkg::KIND_DONE, '0, ptw_pkg::LEVEL_PML4, '0, '0, 1'b1));
      // Full four-level walk; high entry bits above the frame, size bit at PT ignored.
      add_row(start_beat(48'hA5A5_5A5A_C3C3, 48'h0123_4567_8ABC), 1'b0, '0);
      add_row(data_beat(64'hFFF0_0000_0001_2003), 1'b0, '0);
      add_row(data_beat(64'h0000_0ABC_DEF0_1061), 1'b0, '0);
      add_row(data_beat(64'h8000_7FFF_FFFF_F003), 1'b0, '0);
      add_row(data_beat(64'h0000_0000_0000_0081), 1'b0, '0);
      // Size bit at PML4 is not examined; a 2M page at the PD level.
      add_row(start_beat(48'h0000_4020_1000, 48'h0000_0000_2000), 1'b0, '0);
      add_row(data_beat(64'h0000_0000_0003_0081), 1'b0, '0);
      add_row(data_beat(64'h0000_0000_0004_0001), 1'b0, '0);
      add_row(data_beat(64'h0000_0000_0005_0083), 1'b0, '0);
      // Not-present PDPT entry with the size bit set, and a start in between.
      add_row(start_beat(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000), 1'b0, '0);
      add_row(start_beat(48'h1234_5678_9ABC, 48'hFFFF_FFFF_FFFF), 1'b1,
              answer_of(ptw_pkg::KIND_IGNORED, '0, ptw_pkg::LEVEL_PML4, '0, '0, 1'b0));
      add_row(data_beat(64'h0000_0000_0006_0001), 1'b0, '0);
      add_row(data_beat(64'h0000_0000_0000_0080), 1'b0, '0);
      // Zero address under an all-ones root; PD entry not present.
      add_row(start_beat('0, '1), 1'b1,
              answer_of(ptw_pkg::KIND_READ, 48'hFFFF_FFFF_F000, ptw_pkg::LEVEL_PML4,
                        '0, '0, 1'b0));
      add_row(data_beat(64'h0000_0000_0000_0001), 1'b0, '0);
      add_row(data_beat(64'h0000_0000_0000_0001), 1'b0, '0);
      add_row(data_beat(64'h7FFF_FFFF_FFFF_FFFE), 1'b0, '0);

      send_idle_pct = 27;
      recv_stall_pct = 51;
      for (i = 0; i < directed_rows.size(); i++)
         send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].answer);

      // Random walks: receiver-heavy stall phase, sender-heavy phase, then full rate.
      while (walk_beats < WALK_BEATS) begin
         if (walk_beats >= 2 * WALK_BEATS / 3) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end else if (walk_beats >= WALK_BEATS / 3) begin
            send_idle_pct = 51;
            recv_stall_pct = 27;
         end
         run_walk();
      end
      req_valid <= 1'b0;

      // Drain the outstanding results, then keep watching for extras.
      while (answers_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);

      $display("Ran %0d directed beats, %0d random walks (%0d beats) and %0d stray beats.",
               directed_rows.size(), walks_started, walk_beats, stray_beats);
      $display("Checked %0d results: %0d walks ended, %0d beats ignored, %0d mismatches.",
               answers_seen, walks_ended, beats_ignored, mismatches);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/ptw_pkg.sv
hw/rtl/page_table_walker.sv
hw/rtl/ptw_checker.sv
tb/sv/tb.sv
